FILE: rtl/core/yca_pkg.sv
package yca_pkg;

  localparam int MAX_PAIRS_DEF = 1024;
  localparam int MAX_ROWS_DEF  = 4096;

  localparam logic [11:0] LINE_WIDTH_RST   = 12'd640;
  localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;

  typedef enum logic [0:0] {
    CFG_LINE_WIDTH   = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] luma0;
    logic [7:0] cb_in;
    logic [7:0] luma1;
    logic [7:0] cr_in;
  } in_t;

  typedef struct packed {
    logic [7:0]  luma_a;
    logic [7:0]  luma_b;
    logic [11:0] row_index;
    logic [9:0]  pair_index;
    logic        chroma_valid;
    logic [7:0]  cb_mean;
    logic [7:0]  cr_mean;
    logic        frame_end;
  } out_t;

  // raster position of the item being accepted
  typedef struct packed {
    logic [11:0] row_index;
    logic [9:0]  pair_index;
    logic        odd;
    logic        frame_end;
  } pos_t;

endpackage

FILE: rtl/core/yuyv_to_i420_chroma_average_core.sv
// YUYV 4:2:2 to 4:2:0 converter: one macropixel transfer per clock unless the output stalls; each
// item is registered in a holding stage, then in the output register. The line store takes one
// access per item (a write of Cb/Cr on even rows, a read on odd rows) through a MAX_PAIRS x 16
// RAM. Luma passes through tagged with row and pair position; odd rows carry the truncated mean
// of the stored and current chroma. The store has no clearing pass, so an odd row must follow
// an even row that wrote the same columns. Configuration writes are always ready and take effect
// at once; the position counters keep their values across a change and wrap at the new limits.
module yuyv_to_i420_chroma_average_core #(
  parameter int MAX_PAIRS = yca_pkg::MAX_PAIRS_DEF,
  parameter int MAX_ROWS  = yca_pkg::MAX_ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  yca_pkg::in_t      in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output yca_pkg::out_t     out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  yca_pkg::cfg_idx_t cfg_index,
  input  logic [12:0]       cfg_data
);

  localparam int AW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

  logic [11:0]   line_width_r, line_width_nxt;
  logic [12:0]   frame_height_r, frame_height_nxt;
  logic          accept;
  logic          busy;
  yca_pkg::pos_t pos;
  logic [AW-1:0] addr;
  logic [15:0]   held;

  assign cfg_ready = 1'b1;

  always_comb begin
    line_width_nxt   = line_width_r;
    frame_height_nxt = frame_height_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        yca_pkg::CFG_LINE_WIDTH:   line_width_nxt   = cfg_data[11:0];
        yca_pkg::CFG_FRAME_HEIGHT: frame_height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= yca_pkg::LINE_WIDTH_RST;
      frame_height_r <= yca_pkg::FRAME_HEIGHT_RST;
    end else begin
      line_width_r   <= line_width_nxt;
      frame_height_r <= frame_height_nxt;
    end
  end

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  yca_pos #(
    .MAX_PAIRS (MAX_PAIRS),
    .MAX_ROWS  (MAX_ROWS)
  ) u_pos (
    .clk          (clk),
    .rst_n        (rst_n),
    .line_width   (line_width_r),
    .frame_height (frame_height_r),
    .step         (accept),
    .pos          (pos),
    .addr         (addr)
  );

  yca_ram #(
    .WIDTH (16),
    .DEPTH (MAX_PAIRS)
  ) u_line (
    .clk   (clk),
    .we    (accept && !pos.odd),
    .waddr (addr),
    .wdata ({in_data.cr_in, in_data.cb_in}),
    .re    (accept && pos.odd),
    .raddr (addr),
    .rdata (held)
  );

  yca_avg u_avg (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_item   (in_data),
    .in_pos    (pos),
    .held      (held),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/core/yca_ram.sv
module yca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/yca_pos.sv
module yca_pos #(
  parameter int MAX_PAIRS = yca_pkg::MAX_PAIRS_DEF,
  parameter int MAX_ROWS  = yca_pkg::MAX_ROWS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic [11:0]                                     line_width,
  input  logic [12:0]                                     frame_height,
  input  logic                                            step,
  output yca_pkg::pos_t                                   pos,
  output logic [((MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1)-1:0] addr
);

  localparam int PW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int RW = $clog2(MAX_ROWS);

  logic [PW-1:0] pair_cnt_r, pair_cnt_nxt;
  logic [RW-1:0] row_cnt_r, row_cnt_nxt;
  logic [10:0]   half_w;
  logic [12:0]   pairs;
  logic [13:0]   rows_raw;
  logic [13:0]   rows;
  logic          last_pair;
  logic          last_row;

  always_comb begin
    half_w = line_width[11:1];
    if (half_w == 11'd0) begin
      pairs = 13'd1;
    end else if ({2'b00, half_w} > 13'(MAX_PAIRS)) begin
      pairs = 13'(MAX_PAIRS);
    end else begin
      pairs = {2'b00, half_w};
    end
    rows_raw = {1'b0, frame_height[12:1], 1'b0};
    if (rows_raw < 14'd2) begin
      rows = 14'd2;
    end else if (rows_raw > 14'(MAX_ROWS)) begin
      rows = 14'(MAX_ROWS);
    end else begin
      rows = rows_raw;
    end
  end

  assign last_pair = (13'(pair_cnt_r) + 13'd1) >= pairs;
  assign last_row  = (14'(row_cnt_r) + 14'd1) >= rows;

  always_comb begin
    pair_cnt_nxt = pair_cnt_r;
    row_cnt_nxt  = row_cnt_r;
    if (step) begin
      if (last_pair) begin
        pair_cnt_nxt = '0;
        row_cnt_nxt  = last_row ? '0 : row_cnt_r + RW'(1);
      end else begin
        pair_cnt_nxt = pair_cnt_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_cnt_r <= '0;
      row_cnt_r  <= '0;
    end else begin
      pair_cnt_r <= pair_cnt_nxt;
      row_cnt_r  <= row_cnt_nxt;
    end
  end

  assign pos.row_index  = 12'(row_cnt_r);
  assign pos.pair_index = 10'(pair_cnt_r);
  assign pos.odd        = row_cnt_r[0];
  assign pos.frame_end  = last_pair && last_row;
  assign addr           = pair_cnt_r;

  a_wrap_on_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    step && last_pair && last_row |=> pair_cnt_r == '0 && row_cnt_r == '0)
    else $error("counters did not wrap after frame end");

  a_pair_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> int'(pair_cnt_r) < MAX_PAIRS)
    else $error("pair counter out of range");

endmodule

FILE: rtl/core/yca_avg.sv
module yca_avg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  yca_pkg::in_t   in_item,
  input  yca_pkg::pos_t  in_pos,
  input  logic [15:0]    held,
  output logic           busy,
  output logic           out_valid,
  input  logic           out_stall,
  output yca_pkg::out_t  out_data
);

  logic          b_valid_r, b_valid_nxt;
  yca_pkg::in_t  b_item_r;
  yca_pkg::pos_t b_pos_r;
  logic          o_valid_r, o_valid_nxt;
  yca_pkg::out_t o_data_r, o_data_nxt;
  logic          c_free;
  logic          b_adv;
  logic [8:0]    cb_sum;
  logic [8:0]    cr_sum;

  assign c_free = !o_valid_r || !out_stall;
  assign b_adv  = b_valid_r && c_free;
  assign busy   = b_valid_r && !c_free;

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (accept) begin
      b_valid_nxt = 1'b1;
    end else if (b_adv) begin
      b_valid_nxt = 1'b0;
    end
    o_valid_nxt = o_valid_r;
    if (b_adv) begin
      o_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      o_valid_nxt = 1'b0;
    end
  end

  // stored line: Cb in low byte, Cr in high byte
  assign cb_sum = {1'b0, held[7:0]} + {1'b0, b_item_r.cb_in};
  assign cr_sum = {1'b0, held[15:8]} + {1'b0, b_item_r.cr_in};

  always_comb begin
    o_data_nxt.luma_a       = b_item_r.luma0;
    o_data_nxt.luma_b       = b_item_r.luma1;
    o_data_nxt.row_index    = b_pos_r.row_index;
    o_data_nxt.pair_index   = b_pos_r.pair_index;
    o_data_nxt.chroma_valid = b_pos_r.odd;
    o_data_nxt.cb_mean      = b_pos_r.odd ? cb_sum[8:1] : 8'd0;
    o_data_nxt.cr_mean      = b_pos_r.odd ? cr_sum[8:1] : 8'd0;
    o_data_nxt.frame_end    = b_pos_r.frame_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_item_r <= in_item;
      b_pos_r  <= in_pos;
    end
    if (b_adv) begin
      o_data_r <= o_data_nxt;
    end
  end

  assign out_valid = o_valid_r;
  assign out_data  = o_data_r;

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    b_valid_r && !c_free |=> b_valid_r && $stable(b_item_r) && $stable(b_pos_r))
    else $error("waiting item lost or changed");

  a_no_accept_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !accept)
    else $error("transfer taken while stage blocked");

  a_even_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    o_valid_r && !o_data_r.chroma_valid |-> o_data_r.cb_mean == 8'd0
      && o_data_r.cr_mean == 8'd0)
    else $error("chroma on even row");

endmodule

FILE: sim/yuyv_to_i420_chroma_average_core_tb.sv
`timescale 1ns / 1ps

module yuyv_to_i420_chroma_average_core_tb;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_LEN    = 120;
  localparam int DRAIN_WAIT  = 4;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  yca_pkg::in_t      in_data;
  logic              out_valid;
  logic              out_stall = 1'b0;
  yca_pkg::out_t     out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  yca_pkg::cfg_idx_t cfg_index;
  logic [12:0]       cfg_data;

  yuyv_to_i420_chroma_average_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // shadow of the converter state
  logic [11:0] cur_width;
  logic [12:0] cur_height;
  logic [15:0] chroma_mem [0:yca_pkg::MAX_PAIRS_DEF-1];
  bit          line_written [0:yca_pkg::MAX_PAIRS_DEF-1];
  int unsigned pair_pos;
  int unsigned row_pos;

  yca_pkg::out_t chroma_expect_q[$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   hold_req = 0;
  int   hold_ack = 0;
  int   hold_left = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic int unsigned pair_limit(logic [11:0] w);
    int unsigned p;
    p = w >> 1;
    if (p < 1) p = 1;
    if (p > yca_pkg::MAX_PAIRS_DEF) p = yca_pkg::MAX_PAIRS_DEF;
    return p;
  endfunction

  function automatic int unsigned row_limit(logic [12:0] h);
    int unsigned r;
    r = h & 13'h1FFE;
    if (r < 2) r = 2;
    if (r > yca_pkg::MAX_ROWS_DEF) r = yca_pkg::MAX_ROWS_DEF;
    return r;
  endfunction

  function automatic yca_pkg::out_t predict_420(yca_pkg::in_t px);
    yca_pkg::out_t r;
    int unsigned   pairs;
    int unsigned   rows;
    int unsigned   col;
    bit            odd_row;
    bit            last_pair;
    bit            last_row;
    logic [15:0]   held;
    pairs = pair_limit(cur_width);
    rows = row_limit(cur_height);
    col = pair_pos % yca_pkg::MAX_PAIRS_DEF;
    odd_row = row_pos[0];
    last_pair = (pair_pos + 1 >= pairs);
    last_row = (row_pos + 1 >= rows);
    r = '0;
    r.luma_a = px.luma0;
    r.luma_b = px.luma1;
    r.row_index = row_pos[11:0];
    r.pair_index = pair_pos[9:0];
    r.chroma_valid = odd_row;
    r.frame_end = last_pair && last_row;
    if (odd_row) begin
      if (!line_written[col]) begin
        $error("line store read before write, column %0d", col);
        mismatch_count++;
      end
      held = chroma_mem[col];
      r.cb_mean = 8'((9'(held[7:0]) + 9'(px.cb_in)) >> 1);
      r.cr_mean = 8'((9'(held[15:8]) + 9'(px.cr_in)) >> 1);
    end else begin
      chroma_mem[col] = {px.cr_in, px.cb_in};
      line_written[col] = 1'b1;
    end
    if (last_pair) begin
      pair_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      pair_pos = pair_pos + 1;
    end
    return r;
  endfunction

  // true when an odd row under the given width never reaches an unwritten column
  function automatic bit store_ready(int unsigned pairs);
    if (!row_pos[0] || pair_pos >= pairs) return 1'b1;
    for (int unsigned c = pair_pos; c < pairs; c++) begin
      if (!line_written[c]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic yca_pkg::in_t rand_pixel();
    yca_pkg::in_t p;
    p.luma0 = rand_byte();
    p.cb_in = rand_byte();
    p.luma1 = rand_byte();
    p.cr_in = rand_byte();
    return p;
  endfunction

  function automatic logic [12:0] pick_width();
    case ($urandom_range(0, 9))
      0: return 13'($urandom_range(0, 3));
      1: return 13'($urandom_range(41, 8191));
      2: return 13'd2048;
      default: return 13'($urandom_range(2, 40));
    endcase
  endfunction

  function automatic logic [12:0] pick_height();
    case ($urandom_range(0, 9))
      0: return 13'($urandom_range(0, 3));
      1: return 13'($urandom_range(17, 8191));
      2: return 13'd4096;
      default: return 13'($urandom_range(2, 16));
    endcase
  endfunction

  always @(posedge clk) begin
    yca_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (chroma_expect_q.size() == 0) begin
        $error("result transfer with nothing expected");
        mismatch_count++;
      end else begin
        want = chroma_expect_q.pop_front();
        if (out_data.luma_a !== want.luma_a) begin
          $error("luma_a expected %0d got %0d", want.luma_a, out_data.luma_a);
          mismatch_count++;
        end
        if (out_data.luma_b !== want.luma_b) begin
          $error("luma_b expected %0d got %0d", want.luma_b, out_data.luma_b);
          mismatch_count++;
        end
        if (out_data.row_index !== want.row_index) begin
          $error("row_index expected %0d got %0d", want.row_index, out_data.row_index);
          mismatch_count++;
        end
        if (out_data.pair_index !== want.pair_index) begin
          $error("pair_index expected %0d got %0d", want.pair_index, out_data.pair_index);
          mismatch_count++;
        end
        if (out_data.chroma_valid !== want.chroma_valid) begin
          $error("chroma_valid expected %0d got %0d", want.chroma_valid,
                 out_data.chroma_valid);
          mismatch_count++;
        end
        if (out_data.cb_mean !== want.cb_mean) begin
          $error("cb_mean expected %0d got %0d", want.cb_mean, out_data.cb_mean);
          mismatch_count++;
        end
        if (out_data.cr_mean !== want.cr_mean) begin
          $error("cr_mean expected %0d got %0d", want.cr_mean, out_data.cr_mean);
          mismatch_count++;
        end
        if (out_data.frame_end !== want.frame_end) begin
          $error("frame_end expected %0d got %0d", want.frame_end, out_data.frame_end);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_pixel(yca_pkg::in_t px);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= px;
    do @(posedge clk); while (in_stall);
    chroma_expect_q.push_back(predict_420(px));
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (chroma_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(yca_pkg::cfg_idx_t idx, logic [12:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == yca_pkg::CFG_LINE_WIDTH) cur_width = val[11:0];
    else cur_height = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // pad the current line until the new width cannot expose unwritten columns
  task automatic retune(logic [12:0] w, logic [12:0] h);
    while (!store_ready(pair_limit(w[11:0]))) send_pixel(rand_pixel());
    settle();
    write_reg(yca_pkg::CFG_LINE_WIDTH, w);
    write_reg(yca_pkg::CFG_FRAME_HEIGHT, h);
  endtask

  task automatic test_directed_extremes();
    logic [7:0]   corner_byte [0:7];
    yca_pkg::in_t px;
    corner_byte = '{8'h00, 8'hFF, 8'h01, 8'hFE, 8'hFF, 8'hFF, 8'h00, 8'h01};
    send_idle_pct = 0;
    stall_pct = 0;
    for (int i = 0; i < 16; i++) begin
      // first pairs run at the reset geometry, then the line shrinks mid-row
      if (i == 3) retune(13'd8, 13'd4);
      px.luma0 = corner_byte[(i + 1) % 8];
      px.cb_in = corner_byte[i % 8];
      px.luma1 = corner_byte[(i + 2) % 8];
      px.cr_in = corner_byte[(i + 4) % 8];
      send_pixel(px);
    end
    settle();
  endtask

  task automatic test_tiny_geometry();
    retune(13'd0, 13'd0);
    repeat (6) send_pixel(rand_pixel());
    retune(13'd1, 13'd1);
    repeat (5) send_pixel(rand_pixel());
    retune(13'd3, 13'd3);
    repeat (4) send_pixel(rand_pixel());
    retune(13'd2, 13'd2);
    repeat (4) send_pixel(rand_pixel());
    settle();
  endtask

  task automatic test_mid_frame_change();
    retune(13'd16, 13'd8);
    while (!(row_pos == 2 && pair_pos == 5)) send_pixel(rand_pixel());
    // both counters now sit beyond the new limits
    retune(13'd6, 13'd2);
    repeat (8) send_pixel(rand_pixel());
    settle();
  endtask

  task automatic test_backpressure();
    retune(13'd20, 13'd6);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = hold_req + 1;
    repeat (40) send_pixel(rand_pixel());
    settle();
    stall_pct = 20;
    repeat (20) send_pixel(rand_pixel());
    settle();
  endtask

  task automatic test_random_traffic();
    int idle_set [0:3][0:1];
    idle_set = '{'{0, 0}, '{45, 0}, '{0, 45}, '{31, 31}};
    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < 2; k++) begin
        send_idle_pct = 0;
        stall_pct = 0;
        retune(pick_width(), pick_height());
        send_idle_pct = idle_set[ph][0];
        stall_pct = idle_set[ph][1];
        repeat (45) send_pixel(rand_pixel());
        settle();
      end
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_tall_frame();
    // one pair per line and the deepest frame: rows keep counting with no early wrap
    retune(13'd2, 13'h1FFF);
    send_idle_pct = 5;
    stall_pct = 5;
    repeat (60) send_pixel(rand_pixel());
    settle();
  endtask

  task automatic test_wide_line();
    // width saturates at the store depth
    send_idle_pct = 0;
    stall_pct = 0;
    retune(13'h1FFF, 13'd4);
    send_idle_pct = 5;
    stall_pct = 5;
    repeat (40) send_pixel(rand_pixel());
    settle();
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = yca_pkg::CFG_LINE_WIDTH;
    cfg_data = '0;
    cur_width = yca_pkg::LINE_WIDTH_RST;
    cur_height = yca_pkg::FRAME_HEIGHT_RST;
    pair_pos = 0;
    row_pos = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_directed_extremes();
    test_tiny_geometry();
    test_mid_frame_change();
    test_backpressure();
    test_random_traffic();
    test_tall_frame();
    test_wide_line();
    settle();

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
